[rtl/mbwq_pkg.sv]
// shared types, register map and reset values for the button window qualifier
package mbwq_pkg;

	localparam int AddrW = 5;
	localparam int DataW = 32;

	localparam logic [11:0] AdcThresholdRst = 12'd1200;
	localparam logic [15:0] EdgeLockoutRst  = 16'd2000;
	localparam logic [15:0] WindowMsRst     = 16'd100;
	localparam logic [7:0]  HitsNeededRst   = 8'd3;
	localparam logic [15:0] HoldoffMsRst    = 16'd200;

	localparam logic [7:0] HitsMax = 8'd255;

	typedef enum logic [2:0] {
		REG_ADC_THRESHOLD = 3'd0,
		REG_EDGE_LOCKOUT  = 3'd1,
		REG_WINDOW_MS     = 3'd2,
		REG_HITS_NEEDED   = 3'd3,
		REG_HOLDOFF_MS    = 3'd4
	} reg_idx_t;

	typedef enum logic {
		FUNC_EDGE = 1'b0,
		FUNC_POLL = 1'b1
	} func_t;

	typedef struct packed {
		logic [11:0] adc_threshold;
		logic [15:0] edge_lockout_us;
		logic [15:0] win_len_ms;
		logic [7:0]  hits_needed;
		logic [15:0] press_holdoff_ms;
	} cfg_t;

	typedef struct packed {
		logic        func;
		logic [31:0] now_us;
		logic [31:0] now_ms;
		logic        sample_valid;
		logic [11:0] row_sample;
		logic        credit_window_open;
		logic [7:0]  credits;
	} item_t;

	typedef struct packed {
		logic       edge_accepted;
		logic       hit;
		logic       fire_relay;
		logic [7:0] pulse_count;
		logic       close_window;
		logic       no_funds;
	} res_t;

endpackage

[rtl/mbwq_regs.sv]
// apb configuration registers
module mbwq_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mbwq_pkg::AddrW-1:0]   paddr,
	input  logic [mbwq_pkg::DataW-1:0]   pwdata,
	output logic [mbwq_pkg::DataW-1:0]   prdata,
	output logic                         pready,
	output mbwq_pkg::cfg_t               cfg
);
	import mbwq_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adc_threshold    <= AdcThresholdRst;
			cfg_q.edge_lockout_us  <= EdgeLockoutRst;
			cfg_q.win_len_ms       <= WindowMsRst;
			cfg_q.hits_needed      <= HitsNeededRst;
			cfg_q.press_holdoff_ms <= HoldoffMsRst;
		end else if (wr_en) begin
			case (idx)
				REG_ADC_THRESHOLD: cfg_q.adc_threshold    <= pwdata[11:0];
				REG_EDGE_LOCKOUT:  cfg_q.edge_lockout_us  <= pwdata[15:0];
				REG_WINDOW_MS:     cfg_q.win_len_ms       <= pwdata[15:0];
				REG_HITS_NEEDED:   cfg_q.hits_needed      <= pwdata[7:0];
				REG_HOLDOFF_MS:    cfg_q.press_holdoff_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ADC_THRESHOLD: prdata = {20'd0, cfg_q.adc_threshold};
			REG_EDGE_LOCKOUT:  prdata = {16'd0, cfg_q.edge_lockout_us};
			REG_WINDOW_MS:     prdata = {16'd0, cfg_q.win_len_ms};
			REG_HITS_NEEDED:   prdata = {24'd0, cfg_q.hits_needed};
			REG_HOLDOFF_MS:    prdata = {16'd0, cfg_q.press_holdoff_ms};
			default:           prdata = '0;
		endcase
	end

endmodule

[rtl/mbwq_eval.sv]
// qualifier state and combinational evaluation of one request
module mbwq_eval (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  mbwq_pkg::item_t item,
	input  mbwq_pkg::cfg_t  cfg,
	output mbwq_pkg::res_t  res
);
	import mbwq_pkg::*;

	logic [31:0] last_edge_q;
	logic [7:0]  hits_q;
	logic [31:0] win_start_q;
	logic        pending_q;
	logic [31:0] last_press_q;

	logic [31:0] edge_gap;
	logic [31:0] win_gap;
	logic [31:0] press_gap;
	logic        is_poll;
	logic        edge_ok;
	logic        is_hit;
	logic [7:0]  hits_inc;
	logic        win_restart;
	logic        press_ok;
	logic        fire;

	assign is_poll     = (item.func == FUNC_POLL);
	assign edge_gap    = item.now_us - last_edge_q;
	assign win_gap     = item.now_ms - win_start_q;
	assign press_gap   = item.now_ms - last_press_q;
	assign edge_ok     = !is_poll && (edge_gap >= {16'd0, cfg.edge_lockout_us});
	assign is_hit      = edge_ok && item.sample_valid && (item.row_sample < cfg.adc_threshold);
	assign hits_inc    = (hits_q == HitsMax) ? hits_q : hits_q + 8'd1;
	assign win_restart = is_poll && (win_gap >= {16'd0, cfg.win_len_ms});
	assign press_ok    = is_poll && pending_q && (press_gap >= {16'd0, cfg.press_holdoff_ms});
	assign fire        = press_ok && item.credit_window_open;

	always_comb begin
		res.edge_accepted = edge_ok;
		res.hit           = is_hit;
		res.fire_relay    = fire;
		res.pulse_count   = fire ? item.credits : 8'd0;
		res.close_window  = fire;
		res.no_funds      = press_ok && !item.credit_window_open;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q  <= '0;
			hits_q       <= '0;
			win_start_q  <= '0;
			pending_q    <= 1'b0;
			last_press_q <= '0;
		end else if (advance) begin
			if (edge_ok) begin
				last_edge_q <= item.now_us;
			end
			if (is_hit) begin
				hits_q <= hits_inc;
				if (hits_inc >= cfg.hits_needed) begin
					pending_q <= 1'b1;
				end
			end
			if (win_restart) begin
				hits_q      <= '0;
				win_start_q <= item.now_ms;
			end
			if (is_poll) begin
				pending_q <= 1'b0;
			end
			if (press_ok) begin
				last_press_q <= item.now_ms;
			end
		end
	end

endmodule

[rtl/matrix_button_window_qualifier_core.sv]
// top level of the matrix button window qualifier
//
// channel   direction  handshake              payload
// in        to block   in_valid / in_ready    func, now_us, now_ms, sample_valid, row_sample,
//                                             credit_window_open, credits
// out       from block out_valid / out_ready  edge_accepted, hit, fire_relay, pulse_count,
//                                             close_window, no_funds
// apb       to block   psel/penable/pready    pwrite, paddr, pwdata, prdata
//
// one request per cycle sustained while out_ready is high; a request lands in the input
// register, is evaluated against the state in the next cycle and its result sits in the
// output register after that, where it stays valid until the result handshake
// reset clears the state, the configuration to its defaults and the valid flags of both register stages
// a stalled output holds the evaluation; the input register still takes one more request
module matrix_button_window_qualifier_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         func,
	input  logic [31:0]                  now_us,
	input  logic [31:0]                  now_ms,
	input  logic                         sample_valid,
	input  logic [11:0]                  row_sample,
	input  logic                         credit_window_open,
	input  logic [7:0]                   credits,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         edge_accepted,
	output logic                         hit,
	output logic                         fire_relay,
	output logic [7:0]                   pulse_count,
	output logic                         close_window,
	output logic                         no_funds,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mbwq_pkg::AddrW-1:0]   paddr,
	input  logic [mbwq_pkg::DataW-1:0]   pwdata,
	output logic [mbwq_pkg::DataW-1:0]   prdata,
	output logic                         pready
);
	import mbwq_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_s2;
	logic  valid_s2;
	logic  advance;
	logic  take;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	mbwq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mbwq_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.func               <= func;
			item_s1.now_us             <= now_us;
			item_s1.now_ms             <= now_ms;
			item_s1.sample_valid       <= sample_valid;
			item_s1.row_sample         <= row_sample;
			item_s1.credit_window_open <= credit_window_open;
			item_s1.credits            <= credits;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign edge_accepted = res_s2.edge_accepted;
	assign hit           = res_s2.hit;
	assign fire_relay    = res_s2.fire_relay;
	assign pulse_count   = res_s2.pulse_count;
	assign close_window  = res_s2.close_window;
	assign no_funds      = res_s2.no_funds;

`ifndef SYNTHESIS
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !((edge_accepted || hit) && (fire_relay || no_funds)))
		else $error("edge and poll results mixed");

	a_fire_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fire_relay == close_window) && !(fire_relay && no_funds))
		else $error("press outcome inconsistent");

	a_hit_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> edge_accepted)
		else $error("hit without accepted edge");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ready |=> valid_s1 && valid_s2)
		else $error("request lost under stall");
`endif

endmodule
